FILE: sv/trle_pkg.sv
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types, constants and helper functions for the text run-length
// encoder: channel payloads, the run descriptor queue entry and BCD helpers.
// ----------------------------------------------------------------------------
package trle_pkg;

  localparam int DIGITS  = 5;
  localparam int DIGIT_W = 4;
  localparam int POS_W   = 3;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  typedef logic [DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  localparam bcd_t BCD_ONE = bcd_t'(1);

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       string_done;
  } out_t;

  typedef struct packed {
    logic             run_v;
    logic [7:0]       run_sym;
    bcd_t             digits;
    logic [POS_W-1:0] ndig;
    logic             tail_v;
    logic [7:0]       tail_sym;
    logic             eos;
  } entry_t;

  function automatic bcd_t bcd_inc(input bcd_t value);
    bcd_t res;
    logic carry;
    res   = value;
    carry = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (carry) begin
        if (value[i] == DIGIT_W'(9)) begin
          res[i] = '0;
        end else begin
          res[i] = value[i] + DIGIT_W'(1);
          carry  = 1'b0;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [POS_W-1:0] bcd_ndig(input bcd_t value);
    logic [POS_W-1:0] n;
    n = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (value[i] != '0) begin
        n = POS_W'(i + 1);
      end
    end
    if (value == BCD_ONE) begin
      n = '0;
    end
    return n;
  endfunction

endpackage

FILE: sv/trle_front.sv
// ----------------------------------------------------------------------------
// trle_front
// Accepts characters, tracks the open run and its length in binary and BCD,
// and queues a descriptor of every run that closes.
// ----------------------------------------------------------------------------
module trle_front import trle_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  in_t    in_data,
  input  logic   q_full,
  output logic   q_push,
  output entry_t q_data
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [7:0]             run_sym_r, run_sym_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  bcd_t                   bcd_r, bcd_nxt, bcd_inc_v;
  logic                   open_r, open_nxt;
  logic                   accept, is_digit, same, extend, close, start;
  entry_t                 ent;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    is_digit  = (in_data.symbol >= ASCII_ZERO) && (in_data.symbol <= ASCII_NINE);
    same      = open_r && (in_data.symbol == run_sym_r);
    extend    = !is_digit && same && (count_r != CountMax);
    close     = open_r && !extend;
    start     = !is_digit && !extend;
    bcd_inc_v = bcd_inc(bcd_r);

    run_sym_nxt = run_sym_r;
    count_nxt   = count_r;
    bcd_nxt     = bcd_r;
    open_nxt    = open_r;

    ent          = '0;
    ent.run_sym  = run_sym_r;
    ent.digits   = bcd_r;
    ent.ndig     = bcd_ndig(bcd_r);
    ent.run_v    = close;
    ent.tail_sym = in_data.symbol;
    ent.eos      = in_data.end_of_string;

    if (extend) begin
      count_nxt = count_r + COUNT_WIDTH'(1);
      bcd_nxt   = bcd_inc_v;
    end else if (start) begin
      run_sym_nxt = in_data.symbol;
      count_nxt   = COUNT_WIDTH'(1);
      bcd_nxt     = BCD_ONE;
      open_nxt    = 1'b1;
    end else begin
      run_sym_nxt = '0;
      count_nxt   = '0;
      bcd_nxt     = '0;
      open_nxt    = 1'b0;
    end

    if (in_data.end_of_string) begin
      if (extend) begin
        ent.run_v  = 1'b1;
        ent.digits = bcd_inc_v;
        ent.ndig   = bcd_ndig(bcd_inc_v);
      end
      ent.tail_v  = start;
      run_sym_nxt = '0;
      count_nxt   = '0;
      bcd_nxt     = '0;
      open_nxt    = 1'b0;
    end

    if (!ent.run_v) begin
      ent.ndig = '0;
    end
  end

  assign q_push = accept && (ent.run_v || ent.tail_v);
  assign q_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sym_r <= '0;
      count_r   <= '0;
      bcd_r     <= '0;
      open_r    <= 1'b0;
    end else if (accept) begin
      run_sym_r <= run_sym_nxt;
      count_r   <= count_nxt;
      bcd_r     <= bcd_nxt;
      open_r    <= open_nxt;
    end
  end

endmodule

FILE: sv/trle_fifo.sv
// ----------------------------------------------------------------------------
// trle_fifo
// Short queue of run descriptors between the front and the back end.
// ----------------------------------------------------------------------------
module trle_fifo import trle_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t pop_data,
  output logic   full,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/trle_back.sv
// ----------------------------------------------------------------------------
// trle_back
// Takes run descriptors from the queue and writes out the run character,
// its decimal count digits and any closing single character, one byte per
// cycle while out_stall is low, through an output register.
// ----------------------------------------------------------------------------
module trle_back import trle_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_empty,
  input  entry_t q_data,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_stall,
  output out_t   out_data
);

  entry_t           ent_r, ent_nxt;
  logic             have_r, have_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, last_pos, dig_idx;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  logic             out_ready, emit, final_byte;
  logic [7:0]       cur_byte;

  always_comb begin
    out_ready  = !out_valid_r || !out_stall;
    last_pos   = ent_r.tail_v ? ent_r.ndig + POS_W'(1) : ent_r.ndig;
    final_byte = (pos_r == last_pos);
    dig_idx    = ent_r.ndig - pos_r;

    if (pos_r == '0) begin
      cur_byte = ent_r.run_sym;
    end else if (pos_r <= ent_r.ndig) begin
      cur_byte = ASCII_ZERO + 8'(ent_r.digits[dig_idx]);
    end else begin
      cur_byte = ent_r.tail_sym;
    end

    emit  = have_r && out_ready;
    q_pop = !q_empty && (!have_r || (emit && final_byte));

    have_nxt = have_r;
    ent_nxt  = ent_r;
    pos_nxt  = pos_r;
    if (q_pop) begin
      have_nxt = 1'b1;
      ent_nxt  = q_data;
      pos_nxt  = q_data.run_v ? '0 : POS_W'(1);
    end else if (emit && final_byte) begin
      have_nxt = 1'b0;
    end else if (emit) begin
      pos_nxt = pos_r + POS_W'(1);
    end

    out_nxt.out_byte    = cur_byte;
    out_nxt.last        = final_byte;
    out_nxt.string_done = final_byte && ent_r.eos;
    out_valid_nxt       = out_ready ? emit : out_valid_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    pos_r <= pos_nxt;
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/text_run_length_encoder.sv
// ----------------------------------------------------------------------------
// text_run_length_encoder
// Run-length encoder for text: each run is written as its character followed
// by the run length in ASCII decimal when longer than one.
//
//   Channel   Ports                        Beat carries
//   input     in_valid, in_stall, in_data  symbol, end_of_string
//   output    out_valid, out_stall, out_data  out_byte, last, string_done
//
// One character is accepted per cycle unless stalled; one encoded byte
// leaves per cycle unless out_stall is high; the output register sets
// the pace.
// Input stalls only while the descriptor queue is full.
// Reset clears the open run and empties the queue and output register.
// ----------------------------------------------------------------------------
module text_run_length_encoder import trle_pkg::*; #(
  parameter int COUNT_WIDTH = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_wr_data, q_rd_data;

  trle_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  trle_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  trle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_done |-> out_data.last)
    else $error("string_done seen on a beat that is not last");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full || q_pop)
    else $error("run queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("run queue read while empty");

endmodule
